FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, sampled on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define PPS_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Implication checked at the same edge.
`define PPS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: design/pps_pkg.sv
// ----------------------------------------------------------------------------
// pps_pkg
// Types, constants and the arctangent table of the pure pursuit steering block.
// ----------------------------------------------------------------------------
package pps_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ATAN_LEN          = 24;

    localparam int CFG_W  = 22;
    localparam int ADDR_W = 2;

    localparam logic [ADDR_W-1:0] REG_WHEELBASE    = 2'd0;
    localparam logic [ADDR_W-1:0] REG_STEER_GAIN   = 2'd1;
    localparam logic [ADDR_W-1:0] REG_CRUISE_SPEED = 2'd2;

    localparam logic [21:0] WHEELBASE_RST    = 22'd286882;
    localparam logic [15:0] STEER_GAIN_RST   = 16'd39322;
    localparam logic [7:0]  CRUISE_SPEED_RST = 8'd5;

    // 1/K of the CORDIC gain in Q30
    localparam logic [29:0] INV_K_Q30   = 30'd652032874;
    localparam logic [31:0] HALF_TURN   = 32'h8000_0000;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [16:0] GAIN_SCALE  = 17'd92160;
    localparam logic [14:0] STEER_LIMIT = 15'd23040;

    typedef struct packed {
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic [15:0]        heading;
        logic               stop;
        logic               zero;
    } item_t;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [29:0] atan_turn(input logic [4:0] idx);
        logic [29:0] r;
        unique case (idx)
            5'd0:  r = 30'd536870912;
            5'd1:  r = 30'd316933406;
            5'd2:  r = 30'd167458907;
            5'd3:  r = 30'd85004756;
            5'd4:  r = 30'd42667331;
            5'd5:  r = 30'd21354465;
            5'd6:  r = 30'd10679838;
            5'd7:  r = 30'd5340245;
            5'd8:  r = 30'd2670163;
            5'd9:  r = 30'd1335087;
            5'd10: r = 30'd667544;
            5'd11: r = 30'd333772;
            5'd12: r = 30'd166886;
            5'd13: r = 30'd83443;
            5'd14: r = 30'd41722;
            5'd15: r = 30'd20861;
            5'd16: r = 30'd10430;
            5'd17: r = 30'd5215;
            5'd18: r = 30'd2608;
            5'd19: r = 30'd1304;
            5'd20: r = 30'd652;
            5'd21: r = 30'd326;
            5'd22: r = 30'd163;
            5'd23: r = 30'd81;
            default: r = 30'd0;
        endcase
        return r;
    endfunction

endpackage

FILE: design/pps_front.sv
// ----------------------------------------------------------------------------
// pps_front
// Takes a pose, forms the offset to the waypoint and flags a zero offset.
// ----------------------------------------------------------------------------
module pps_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [31:0]  pos_x,
    input  logic signed [31:0]  pos_y,
    input  logic signed [31:0]  goal_x,
    input  logic signed [31:0]  goal_y,
    input  logic signed [15:0]  heading_angle,
    input  logic                stop_request,
    input  logic                q_full,
    output logic                busy,
    output logic                item_valid,
    output pps_pkg::item_t      item
);

    logic           valid_reg;
    pps_pkg::item_t item_reg;
    pps_pkg::item_t item_next;

    assign busy       = valid_reg && q_full;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        item_next.dx      = 33'(goal_x) - 33'(pos_x);
        item_next.dy      = 33'(goal_y) - 33'(pos_y);
        item_next.heading = heading_angle;
        item_next.stop    = stop_request;
        item_next.zero    = (goal_x == pos_x) && (goal_y == pos_y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!busy)
        begin
            valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            item_reg <= item_next;
        end
    end

endmodule

FILE: design/pps_queue.sv
// ----------------------------------------------------------------------------
// pps_queue
// Two-entry queue between front and back; the back drains one entry a cycle.
// ----------------------------------------------------------------------------
module pps_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  pps_pkg::item_t push_item,
    output logic           full,
    output logic           out_valid,
    output pps_pkg::item_t out_item
);

    pps_pkg::item_t slot_reg [2];
    logic [1:0]     count_reg;
    logic [1:0]     count_next;
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic           do_push;
    logic           do_pop;

    assign full      = (count_reg == 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_item  = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = out_valid;

    always_comb
    begin
        count_next = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: design/pps_cordic.sv
// ----------------------------------------------------------------------------
// pps_cordic
// Pipelined CORDIC, one stage per iteration, vectoring or rotation mode.
// ----------------------------------------------------------------------------
module pps_cordic
#(
    parameter int STAGES = pps_pkg::CORDIC_STAGES_DEF,
    parameter int W      = 36,
    parameter int ZW     = 32,
    parameter int SW     = 1,
    parameter bit VECTOR = 1'b1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic signed [W-1:0]  x_in,
    input  logic signed [W-1:0]  y_in,
    input  logic signed [ZW-1:0] z_in,
    input  logic [SW-1:0]        side_in,
    output logic                 out_valid,
    output logic signed [W-1:0]  x_out,
    output logic signed [W-1:0]  y_out,
    output logic signed [ZW-1:0] z_out,
    output logic [SW-1:0]        side_out
);

    logic                 v_reg    [1:STAGES];
    logic signed [W-1:0]  x_reg    [1:STAGES];
    logic signed [W-1:0]  y_reg    [1:STAGES];
    logic signed [ZW-1:0] z_reg    [1:STAGES];
    logic [SW-1:0]        side_reg [1:STAGES];

    genvar i;
    generate
        for (i = 0; i < STAGES; i++)
        begin : g_stage
            localparam logic signed [ZW-1:0] AT = ZW'(pps_pkg::atan_turn(5'(i)));
            logic                 vs;
            logic signed [W-1:0]  xs;
            logic signed [W-1:0]  ys;
            logic signed [ZW-1:0] zs;
            logic [SW-1:0]        ss;
            logic                 dir;
            logic signed [W-1:0]  x_next;
            logic signed [W-1:0]  y_next;
            logic signed [ZW-1:0] z_next;

            if (i == 0)
            begin : g_src_in
                assign vs = in_valid;
                assign xs = x_in;
                assign ys = y_in;
                assign zs = z_in;
                assign ss = side_in;
            end
            else
            begin : g_src_reg
                assign vs = v_reg[i];
                assign xs = x_reg[i];
                assign ys = y_reg[i];
                assign zs = z_reg[i];
                assign ss = side_reg[i];
            end

            // dir high: x += y>>i, y -= x>>i, z += atan
            if (VECTOR)
            begin : g_vec
                assign dir = (ys > 0);
            end
            else
            begin : g_rot
                assign dir = (zs < 0);
            end

            always_comb
            begin
                if (dir)
                begin
                    x_next = xs + (ys >>> i);
                    y_next = ys - (xs >>> i);
                    z_next = zs + AT;
                end
                else
                begin
                    x_next = xs - (ys >>> i);
                    y_next = ys + (xs >>> i);
                    z_next = zs - AT;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[i+1] <= 1'b0;
                end
                else
                begin
                    v_reg[i+1] <= vs;
                end
            end

            always_ff @(posedge clk)
            begin
                x_reg[i+1]    <= x_next;
                y_reg[i+1]    <= y_next;
                z_reg[i+1]    <= z_next;
                side_reg[i+1] <= ss;
            end
        end
    endgenerate

    assign out_valid = v_reg[STAGES];
    assign x_out     = x_reg[STAGES];
    assign y_out     = y_reg[STAGES];
    assign z_out     = z_reg[STAGES];
    assign side_out  = side_reg[STAGES];

endmodule

FILE: design/pps_back.sv
// ----------------------------------------------------------------------------
// pps_back
// Bearing, distance, sin(alpha), steering angle and output scaling pipeline.
// ----------------------------------------------------------------------------
module pps_back
#(
    parameter int STAGES = pps_pkg::CORDIC_STAGES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  pps_pkg::item_t      in_item,
    input  logic [21:0]         wheelbase,
    input  logic [15:0]         steer_gain,
    input  logic [7:0]          cruise_speed,
    output logic                done,
    output logic signed [15:0]  steer_cmd,
    output logic [7:0]          speed_cmd
);

    // ---- offset vectoring: bearing and length
    logic signed [35:0] dx_w;
    logic signed [35:0] dy_w;
    logic               pre_neg;
    logic signed [35:0] v1_x_in;
    logic signed [35:0] v1_y_in;
    logic signed [31:0] v1_z_in;
    logic               v1_valid;
    logic signed [35:0] v1_len;
    logic signed [35:0] v1_y_unused;
    logic signed [31:0] v1_bear;
    logic [17:0]        v1_side;

    assign dx_w    = 36'(in_item.dx);
    assign dy_w    = 36'(in_item.dy);
    assign pre_neg = (dx_w < 0);
    assign v1_x_in = pre_neg ? -dx_w : dx_w;
    assign v1_y_in = pre_neg ? -dy_w : dy_w;
    assign v1_z_in = pre_neg ? $signed(pps_pkg::HALF_TURN) : 32'sd0;

    pps_cordic #(
        .STAGES (STAGES),
        .W      (36),
        .ZW     (32),
        .SW     (18),
        .VECTOR (1'b1)
    ) u_vec_bear (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .x_in      (v1_x_in),
        .y_in      (v1_y_in),
        .z_in      (v1_z_in),
        .side_in   ({in_item.heading, in_item.stop, in_item.zero}),
        .out_valid (v1_valid),
        .x_out     (v1_len),
        .y_out     (v1_y_unused),
        .z_out     (v1_bear),
        .side_out  (v1_side)
    );

    // ---- gain correction of the length, split in two partial products
    logic [34:0] lenu;
    logic        m1_valid_reg;
    logic [47:0] m1_plo_reg;
    logic [46:0] m1_phi_reg;
    logic [31:0] m1_bear_reg;
    logic [15:0] m1_head_reg;
    logic        m1_stop_reg;
    logic        m1_zero_reg;

    assign lenu = (v1_len < 0) ? 35'd0 : v1_len[34:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_valid_reg <= 1'b0;
        end
        else
        begin
            m1_valid_reg <= v1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        m1_plo_reg  <= 48'(lenu[17:0]) * 48'(pps_pkg::INV_K_Q30);
        m1_phi_reg  <= 47'(lenu[34:18]) * 47'(pps_pkg::INV_K_Q30);
        m1_bear_reg <= v1_side[0] ? 32'd0 : v1_bear;
        m1_head_reg <= v1_side[17:2];
        m1_stop_reg <= v1_side[1];
        m1_zero_reg <= v1_side[0];
    end

    // ---- distance and folded look-ahead angle
    logic [64:0]        len_sum;
    logic [31:0]        diff;
    logic signed [32:0] a33;
    logic signed [32:0] alpha_next;
    logic               m2_valid_reg;
    logic [34:0]        m2_dist_reg;
    logic signed [32:0] m2_alpha_reg;
    logic               m2_stop_reg;

    assign len_sum = {m1_phi_reg, 18'd0} + 65'(m1_plo_reg);
    assign diff    = {m1_head_reg, 16'd0} - m1_bear_reg;
    assign a33     = 33'($signed(diff));

    // fold into +-quarter turn using sin(a) = sin(half - a)
    always_comb
    begin
        if (a33 > $signed({1'b0, pps_pkg::QUARTER_TURN}))
        begin
            alpha_next = $signed({1'b0, pps_pkg::HALF_TURN}) - a33;
        end
        else if (a33 < -$signed({1'b0, pps_pkg::QUARTER_TURN}))
        begin
            alpha_next = -$signed({1'b0, pps_pkg::HALF_TURN}) - a33;
        end
        else
        begin
            alpha_next = a33;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m2_valid_reg <= 1'b0;
        end
        else
        begin
            m2_valid_reg <= m1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m2_dist_reg  <= m1_zero_reg ? 35'd0 : len_sum[64:30];
        m2_alpha_reg <= alpha_next;
        m2_stop_reg  <= m1_stop_reg;
    end

    // ---- sin(alpha) by rotation
    logic               sn_valid;
    logic signed [32:0] sn_x_unused;
    logic signed [32:0] sn_s;
    logic signed [32:0] sn_z_unused;
    logic [35:0]        sn_side;

    pps_cordic #(
        .STAGES (STAGES),
        .W      (33),
        .ZW     (33),
        .SW     (36),
        .VECTOR (1'b0)
    ) u_rot_sin (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (m2_valid_reg),
        .x_in      ($signed(33'(pps_pkg::INV_K_Q30))),
        .y_in      (33'sd0),
        .z_in      (m2_alpha_reg),
        .side_in   ({m2_dist_reg, m2_stop_reg}),
        .out_valid (sn_valid),
        .x_out     (sn_x_unused),
        .y_out     (sn_s),
        .z_out     (sn_z_unused),
        .side_out  (sn_side)
    );

    // ---- numerator 2*wheelbase*sin
    logic signed [56:0] num_prod;
    logic               nm_valid_reg;
    logic signed [26:0] nm_n_reg;
    logic [34:0]        nm_dist_reg;
    logic               nm_stop_reg;

    assign num_prod = $signed({1'b0, wheelbase, 1'b0}) * sn_s;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nm_valid_reg <= 1'b0;
        end
        else
        begin
            nm_valid_reg <= sn_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        nm_n_reg    <= num_prod[56:30];
        nm_dist_reg <= sn_side[35:1];
        nm_stop_reg <= sn_side[0];
    end

    // ---- steering angle atan2(n, dist)
    logic               both_zero;
    logic               v2_valid;
    logic signed [36:0] v2_x_unused;
    logic signed [36:0] v2_y_unused;
    logic signed [32:0] v2_theta;
    logic [1:0]         v2_side;

    assign both_zero = (nm_n_reg == 27'sd0) && (nm_dist_reg == 35'd0);

    pps_cordic #(
        .STAGES (STAGES),
        .W      (37),
        .ZW     (33),
        .SW     (2),
        .VECTOR (1'b1)
    ) u_vec_steer (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (nm_valid_reg),
        .x_in      ($signed({2'b00, nm_dist_reg})),
        .y_in      (37'(nm_n_reg)),
        .z_in      (33'sd0),
        .side_in   ({nm_stop_reg, both_zero}),
        .out_valid (v2_valid),
        .x_out     (v2_x_unused),
        .y_out     (v2_y_unused),
        .z_out     (v2_theta),
        .side_out  (v2_side)
    );

    // ---- scale to degrees*256 by gain, split multiply
    logic [32:0]        gk_reg;
    logic [30:0]        lim_prod;
    logic signed [19:0] lim_reg;
    logic signed [32:0] theta;
    logic               s1_valid_reg;
    logic signed [50:0] s1_p0_reg;
    logic signed [49:0] s1_p1_reg;
    logic               s1_stop_reg;

    assign lim_prod = 31'(steer_gain) * 31'(pps_pkg::STEER_LIMIT);
    assign theta    = v2_side[0] ? 33'sd0 : v2_theta;

    // gain-derived factors are registered and follow the register in the next cycle
    always_ff @(posedge clk)
    begin
        gk_reg  <= 33'(steer_gain) * 33'(pps_pkg::GAIN_SCALE);
        lim_reg <= $signed({5'd0, lim_prod[30:16]});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= v2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_p0_reg   <= theta * $signed({1'b0, gk_reg[16:0]});
        s1_p1_reg   <= theta * $signed({1'b0, gk_reg[32:17]});
        s1_stop_reg <= v2_side[1];
    end

    // ---- round and shift
    logic signed [67:0] sc_sum;
    logic               s2_valid_reg;
    logic signed [19:0] s2_steer_reg;
    logic               s2_stop_reg;

    assign sc_sum = (68'(s1_p1_reg) <<< 17) + 68'(s1_p0_reg) + (68'sd1 <<< 47);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_steer_reg <= sc_sum[67:48];
        s2_stop_reg  <= s1_stop_reg;
    end

    // ---- clamp and output
    logic signed [19:0] clamped;
    logic               done_reg;
    logic signed [15:0] steer_reg;
    logic [7:0]         speed_reg;

    always_comb
    begin
        if (s2_steer_reg > lim_reg)
        begin
            clamped = lim_reg;
        end
        else if (s2_steer_reg < -lim_reg)
        begin
            clamped = -lim_reg;
        end
        else
        begin
            clamped = s2_steer_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        steer_reg <= clamped[15:0];
        speed_reg <= s2_stop_reg ? 8'd0 : cruise_speed;
    end

    assign done      = done_reg;
    assign steer_cmd = steer_reg;
    assign speed_cmd = speed_reg;

endmodule

FILE: design/pure_pursuit_steering.sv
// ----------------------------------------------------------------------------
// pure_pursuit_steering
// Fixed-point pure pursuit steering: CORDIC bearing, distance, sin and atan2.
//
//   channel   signals                                  transfer
//   pose      start/busy, pos_*, goal_*, heading,      start && !busy
//             stop_request
//   result    done, steer_cmd, speed_cmd               done (one cycle)
//   config    cfg_we, cfg_addr, cfg_wdata              cfg_we
//
// One pose per cycle. A pose passes the front register, the queue, the three
// CORDIC pipelines in series and the back-end stage registers on its way to done.
// busy only rises if the front/back queue fills, which does not happen since
// the back end drains it every cycle and the receiver cannot stall.
// Reset clears valid state and loads the register defaults.
// ----------------------------------------------------------------------------
module pure_pursuit_steering
#(
    parameter int CORDIC_STAGES = pps_pkg::CORDIC_STAGES_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [pps_pkg::ADDR_W-1:0]  cfg_addr,
    input  logic [pps_pkg::CFG_W-1:0]   cfg_wdata,
    input  logic                        start,
    output logic                        busy,
    input  logic signed [31:0]          pos_x,
    input  logic signed [31:0]          pos_y,
    input  logic signed [31:0]          goal_x,
    input  logic signed [31:0]          goal_y,
    input  logic signed [15:0]          heading_angle,
    input  logic                        stop_request,
    output logic                        done,
    output logic signed [15:0]          steer_cmd,
    output logic [7:0]                  speed_cmd
);

    logic [21:0] wheelbase_reg;
    logic [15:0] steer_gain_reg;
    logic [7:0]  cruise_speed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wheelbase_reg    <= pps_pkg::WHEELBASE_RST;
            steer_gain_reg   <= pps_pkg::STEER_GAIN_RST;
            cruise_speed_reg <= pps_pkg::CRUISE_SPEED_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                pps_pkg::REG_WHEELBASE:    wheelbase_reg    <= cfg_wdata[21:0];
                pps_pkg::REG_STEER_GAIN:   steer_gain_reg   <= cfg_wdata[15:0];
                pps_pkg::REG_CRUISE_SPEED: cruise_speed_reg <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    logic           q_full;
    logic           f_valid;
    pps_pkg::item_t f_item;
    logic           q_valid;
    pps_pkg::item_t q_item;

    pps_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .goal_x        (goal_x),
        .goal_y        (goal_y),
        .heading_angle (heading_angle),
        .stop_request  (stop_request),
        .q_full        (q_full),
        .busy          (busy),
        .item_valid    (f_valid),
        .item          (f_item)
    );

    pps_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_valid),
        .push_item (f_item),
        .full      (q_full),
        .out_valid (q_valid),
        .out_item  (q_item)
    );

    pps_back #(
        .STAGES (CORDIC_STAGES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (q_valid),
        .in_item      (q_item),
        .wheelbase    (wheelbase_reg),
        .steer_gain   (steer_gain_reg),
        .cruise_speed (cruise_speed_reg),
        .done         (done),
        .steer_cmd    (steer_cmd),
        .speed_cmd    (speed_cmd)
    );

endmodule

FILE: design/pps_checker.sv
// ----------------------------------------------------------------------------
// pps_checker
// Port-level checks of the steering block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pps_checker
#(
    parameter int LAT = 3 * pps_pkg::CORDIC_STAGES_DEF + 8
)
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               stop_request,
    input logic               done,
    input logic signed [15:0] steer_cmd,
    input logic [7:0]         speed_cmd
);

    `PPS_ASSERT_ALWAYS(a_never_busy, !busy, "busy raised with a draining queue")
    `PPS_ASSERT_IMPL(a_steer_range, done, (steer_cmd >= -16'sd23040) && (steer_cmd <= 16'sd23040), "steer out of range")
    `PPS_ASSERT_IMPL(a_done_latency, done, $past(start && !busy && rst_n, LAT), "result without transfer")
    `PPS_ASSERT_IMPL(a_stop_speed, done && (speed_cmd != 8'd0), !$past(stop_request, LAT), "speed on stop")

endmodule

bind pure_pursuit_steering pps_checker #(.LAT(3 * CORDIC_STAGES + 8)) u_pps_checker (.*);

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives pose transfers and register writes into pure_pursuit_steering and
// checks every steering/speed result against a fixed-point CORDIC predictor.
// ----------------------------------------------------------------------------

typedef struct {
    logic signed [15:0] steer;
    logic [7:0]         speed;
} steer_result_t;

class steer_scoreboard;
    steer_result_t pending[$];
    int            errors;

    function void note_pose(steer_result_t r);
        pending.push_back(r);
    endfunction

    function void check_result(logic signed [15:0] steer, logic [7:0] speed);
        steer_result_t exp_r;
        if (pending.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected result steer=%0d speed=%0d", $time, steer, speed);
            return;
        end
        exp_r = pending.pop_front();
        if (steer !== exp_r.steer)
        begin
            errors++;
            $display("%0t: steer_cmd expected %0d actual %0d", $time, exp_r.steer, steer);
        end
        if (speed !== exp_r.speed)
        begin
            errors++;
            $display("%0t: speed_cmd expected %0d actual %0d", $time, exp_r.speed, speed);
        end
    endfunction
endclass

module testbench;

    localparam logic [pps_pkg::ADDR_W-1:0] REG_UNUSED = 2'd3;
    localparam int  STAGES  = 16;
    localparam int  LATENCY = 3 * STAGES + 8;
    localparam longint ATAN_TURN [16] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861
    };

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        cfg_we = 1'b0;
    logic [pps_pkg::ADDR_W-1:0]  cfg_addr = '0;
    logic [pps_pkg::CFG_W-1:0]   cfg_wdata = '0;
    logic                        start = 1'b0;
    logic                        busy;
    logic signed [31:0] pos_x = '0, pos_y = '0, goal_x = '0, goal_y = '0;
    logic signed [15:0] heading_angle = '0;
    logic               stop_request = 1'b0;
    logic               done;
    logic signed [15:0] steer_cmd;
    logic [7:0]         speed_cmd;

    // predictor copy of the registers
    longint unsigned m_wheelbase = pps_pkg::WHEELBASE_RST;
    longint unsigned m_gain      = pps_pkg::STEER_GAIN_RST;
    longint unsigned m_cruise    = pps_pkg::CRUISE_SPEED_RST;

    steer_scoreboard sb = new();

    pure_pursuit_steering dut (.*);

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic longint cordic_atan2(longint x, longint y, output longint len);
        longint z, xs, ys;
        z = 0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = 64'sd2147483648;
        end
        for (int i = 0; i < STAGES; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x += ys; y -= xs; z += ATAN_TURN[i];
            end
            else
            begin
                x -= ys; y += xs; z -= ATAN_TURN[i];
            end
        end
        len = x;
        return z;
    endfunction

    function automatic longint cordic_sine(longint a);
        longint x, y, xs, ys;
        x = pps_pkg::INV_K_Q30;
        y = 0;
        for (int i = 0; i < STAGES; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (a >= 0)
            begin
                x -= ys; y += xs; a -= ATAN_TURN[i];
            end
            else
            begin
                x += ys; y -= xs; a += ATAN_TURN[i];
            end
        end
        return y;
    endfunction

    function automatic steer_result_t predict_steer(logic signed [31:0] px,
            logic signed [31:0] py, logic signed [31:0] gx, logic signed [31:0] gy,
            logic [15:0] hdg, logic stp);
        steer_result_t r;
        longint dx, dy, dist_q, len, a, s, n, theta, st, lim;
        logic [31:0] bearing, diff;
        dx = longint'(gx) - longint'(px);
        dy = longint'(gy) - longint'(py);
        bearing = '0;
        dist_q = 0;
        if (dx != 0 || dy != 0)
        begin
            bearing = 32'(cordic_atan2(dx, dy, len));
            if (len < 0)
                len = 0;
            dist_q = longint'((longint'(unsigned'(len)) *
                               longint'(pps_pkg::INV_K_Q30)) >> 30);
        end
        diff = {hdg, 16'h0} - bearing;
        a = longint'({32'h0, diff});
        if (a >= 64'sd2147483648)
            a -= 64'sd4294967296;
        if (a > 64'sd1073741824)
            a = 64'sd2147483648 - a;
        else if (a < -64'sd1073741824)
            a = -64'sd2147483648 - a;
        s = cordic_sine(a);
        n = (2 * longint'(m_wheelbase) * s) >>> 30;
        if (n == 0 && dist_q == 0)
            theta = 0;
        else
            theta = cordic_atan2(dist_q, n, len);
        st = (theta * 92160 * longint'(m_gain) + (64'sd1 <<< 47)) >>> 48;
        lim = (23040 * longint'(m_gain)) >>> 16;
        if (st > lim)
            st = lim;
        if (st < -lim)
            st = -lim;
        r.steer = 16'(st);
        r.speed = stp ? 8'd0 : 8'(m_cruise);
        return r;
    endfunction

    // transfer monitor and result check
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            sb.note_pose(predict_steer(pos_x, pos_y, goal_x, goal_y,
                                       heading_angle, stop_request));
        if (rst_n && done)
            sb.check_result(steer_cmd, speed_cmd);
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // drive one pose; returns right after its accepting edge with start still high
    task automatic send_pose(logic signed [31:0] px, logic signed [31:0] py,
            logic signed [31:0] gx, logic signed [31:0] gy,
            logic signed [15:0] hdg, logic stp, int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pos_x <= px; pos_y <= py; goal_x <= gx; goal_y <= gy;
        heading_angle <= hdg; stop_request <= stp; start <= 1'b1;
        @(negedge clk);
        while (busy)
            @(negedge clk);
        @(posedge clk);
    endtask

    // one write, then the port is left idle before the task returns
    task automatic write_reg(logic [pps_pkg::ADDR_W-1:0] idx,
            logic [pps_pkg::CFG_W-1:0] val);
        cfg_we <= 1'b1; cfg_addr <= idx; cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            pps_pkg::REG_WHEELBASE:    m_wheelbase = val;
            pps_pkg::REG_STEER_GAIN:   m_gain = val[15:0];
            pps_pkg::REG_CRUISE_SPEED: m_cruise = val[7:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic random_poses(int count);
        logic signed [31:0] px, py, gx, gy;
        for (int k = 0; k < count; k++)
        begin
            px = $urandom;
            py = $urandom;
            case ($urandom_range(0, 3))
                0:
                begin
                    gx = $urandom;
                    gy = $urandom;
                end
                1:
                begin
                    gx = px;
                    gy = py + $signed($urandom_range(0, 3)) - 1;
                end
                default:
                begin
                    // nearby waypoint, a few metres out
                    gx = px + $signed(32'($urandom_range(0, 1 << 20))) - (1 << 19);
                    gy = py + $signed(32'($urandom_range(0, 1 << 20))) - (1 << 19);
                end
            endcase
            send_pose(px, py, gx, gy, 16'($urandom), 1'($urandom), pick_gap());
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero offset, both atan2 args zero, zero distance, extremes
        send_pose(0, 0, 0, 0, 16'sd0, 1'b0, 0);
        send_pose(0, 0, 0, 0, 16'sd16384, 1'b1, 0);
        send_pose(0, 0, 0, 0, -16'sd16384, 1'b0, 0);
        send_pose(32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff,
                  -16'sd32768, 1'b0, 0);
        send_pose(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000,
                  16'sd32767, 1'b1, 0);
        send_pose(32'sh8000_0000, 0, 32'sh7fff_ffff, 0, 16'sd0, 1'b0, 1);
        send_pose(0, 32'sh7fff_ffff, 0, 32'sh8000_0000, 16'sd0, 1'b0, 0);
        send_pose(0, 0, 32'sh0001_0000, 0, 16'sd16384, 1'b0, 0);
        send_pose(0, 0, -32'sh0001_0000, 0, 16'sd0, 1'b0, 0);
        send_pose(0, 0, 0, 32'sh0005_0000, 16'sd8192, 1'b0, 2);
        send_pose(0, 0, 1, 0, 16'sd100, 1'b0, 0);
        send_pose(0, 0, 0, -1, -16'sd100, 1'b1, 0);
        send_pose(-32'sh0000_ffff, 5, 32'sh0000_ffff, -5, -16'sd32768, 1'b0, 0);
        random_poses(130);
        drain();

        write_reg(pps_pkg::REG_WHEELBASE, 22'h3f_ffff);
        write_reg(pps_pkg::REG_STEER_GAIN, 22'h3f_ffff);
        write_reg(pps_pkg::REG_CRUISE_SPEED, 22'h3f_ffff);
        write_reg(REG_UNUSED, 22'h00_0000);
        send_pose(0, 0, 0, 0, 16'sd16384, 1'b0, 0);
        random_poses(170);
        drain();

        write_reg(pps_pkg::REG_WHEELBASE, 22'd0);
        write_reg(pps_pkg::REG_STEER_GAIN, 22'd0);
        write_reg(pps_pkg::REG_CRUISE_SPEED, 22'd0);
        random_poses(120);
        drain();

        write_reg(pps_pkg::REG_WHEELBASE, 22'd2097152);
        write_reg(pps_pkg::REG_STEER_GAIN, 22'd65535);
        write_reg(pps_pkg::REG_CRUISE_SPEED, 22'd255);
        random_poses(140);
        drain();

        for (int ph = 0; ph < 3; ph++)
        begin
            write_reg(pps_pkg::REG_WHEELBASE, 22'($urandom));
            write_reg(pps_pkg::REG_STEER_GAIN, 22'($urandom));
            write_reg(pps_pkg::REG_CRUISE_SPEED, 22'($urandom));
            write_reg(REG_UNUSED, 22'($urandom));
            random_poses(100);
            drain();
        end

        repeat (LATENCY + 20) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("pure_pursuit_steering: match");
        else
            $display("pure_pursuit_steering: mismatch");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("pure_pursuit_steering: mismatch");
        $finish;
    end
endmodule
